@@ rtl/rpa_pkg.sv @@
// Shared types, constants and the arctangent table for the axis rotation unit.
package rpa_pkg;

  // Datapath widths of the angle, CORDIC and unit-axis paths
  localparam int KW    = 32;   // unit axis component, Q30
  localparam int XW    = 33;   // CORDIC x/y, Q30
  localparam int ZW    = 36;   // angle accumulator, Q30
  localparam int ANG_W = 32;   // input angle, Q3.28

  localparam int CORDIC_STEPS = 30;
  localparam int RND_SH       = 30;
  localparam int RND_HALF     = 1 << 29;

  // Entry stages, CORDIC cells and product stages
  localparam int PREP_STAGES = 2;
  localparam int POST_STAGES = 6;
  localparam int PIPE_LAT    = PREP_STAGES + CORDIC_STEPS + POST_STAGES;

  localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [XW-1:0] CORDIC_GAIN = 33'sd652032874;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_PX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_PY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_PZ = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z   = 3'd5;

  // Control handed from cell to cell
  typedef struct packed {
    logic valid;
    logic neg;
  } cord_ctl_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic signed [ZW-1:0] atan_step(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:       v = 36'sd843314856;
      1:       v = 36'sd497837829;
      2:       v = 36'sd263043836;
      3:       v = 36'sd133525158;
      4:       v = 36'sd67021686;
      5:       v = 36'sd33543515;
      6:       v = 36'sd16775850;
      7:       v = 36'sd8388437;
      8:       v = 36'sd4194282;
      9:       v = 36'sd2097149;
      default: v = ZW'((longint'(1) << (30 - i)) - longint'(1));
    endcase
    return v;
  endfunction

endpackage

@@ rtl/rpa_cell.sv @@
// One CORDIC rotation cell; carries the translated point along with it.
module rpa_cell #(
  parameter int STEP = 0,
  parameter int TW   = 33
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rpa_pkg::cord_ctl_t                ctl_i,
  input  logic signed [rpa_pkg::XW-1:0]     x_i,
  input  logic signed [rpa_pkg::XW-1:0]     y_i,
  input  logic signed [rpa_pkg::ZW-1:0]     z_i,
  input  logic signed [TW-1:0]              t_i [3],
  output rpa_pkg::cord_ctl_t                ctl_o,
  output logic signed [rpa_pkg::XW-1:0]     x_o,
  output logic signed [rpa_pkg::XW-1:0]     y_o,
  output logic signed [rpa_pkg::ZW-1:0]     z_o,
  output logic signed [TW-1:0]              t_o [3]
);

  localparam logic signed [rpa_pkg::ZW-1:0] ANG = rpa_pkg::atan_step(STEP);

  logic                          valid_r;
  logic                          neg_r;
  logic signed [rpa_pkg::XW-1:0] x_r, y_r;
  logic signed [rpa_pkg::ZW-1:0] z_r;
  logic signed [TW-1:0]          t_r [3];
  logic signed [rpa_pkg::XW-1:0] dx, dy;

  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_i.valid;
    end
  end

  // Rotate toward zero residual angle
  always_ff @(posedge clk) begin
    neg_r <= ctl_i.neg;
    t_r   <= t_i;
    if (!z_i[rpa_pkg::ZW-1]) begin
      x_r <= x_i - dx;
      y_r <= y_i + dy;
      z_r <= z_i - ANG;
    end else begin
      x_r <= x_i + dx;
      y_r <= y_i - dy;
      z_r <= z_i + ANG;
    end
  end

  assign ctl_o = '{valid: valid_r, neg: neg_r};
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;
  assign t_o   = t_r;

endmodule

@@ rtl/rpa_norm.sv @@
// Sequential unit-axis normalizer: sum of squares, square root, three divides.
module rpa_norm #(
  parameter int CW = 32,
  parameter int FB = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start_i,
  input  logic signed [CW-1:0]          d_i [3],
  output logic signed [rpa_pkg::KW-1:0] k_o [3],
  output logic                          busy_o
);

  localparam int KW = rpa_pkg::KW;
  localparam int AW = (CW > 32) ? CW : 32;
  localparam logic [63:0] SHORT_TH = (64'd1 << (2 * FB)) / 64'd1000000000000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_SQ, ST_CHECK, ST_SHIFT, ST_SQRT, ST_DIV_INIT, ST_DIV
  } state_t;

  state_t               state_r;
  logic [AW-1:0]        a_r [3];
  logic                 sgn_r [3];
  logic [63:0]          msq_r;
  logic [1:0]           idx_r;
  logic                 pass_r;
  logic [63:0]          n_r, res_r, sqbit_r;
  logic [4:0]           cnt_r;
  logic [32:0]          s_r, rem_r;
  logic [31:0]          q_r;
  logic signed [KW-1:0] k_r [3];

  logic [2*AW-1:0] sq_full;
  logic [63:0]     msq_sum;
  logic [AW-1:0]   amax;
  logic [63:0]     trial, res_nxt;
  logic            sq_ge;
  logic [63:0]     num;
  logic [33:0]     rem2;
  logic            dv_ge;
  logic [31:0]     q_nxt;
  logic [CW-1:0]   d_abs [3];

  // Square of the selected component and the running sum
  assign sq_full = a_r[idx_r] * a_r[idx_r];
  assign msq_sum = msq_r + sq_full[63:0];

  always_comb begin
    amax = a_r[0];
    if (a_r[1] > amax) amax = a_r[1];
    if (a_r[2] > amax) amax = a_r[2];
  end

  // Square root step, two bits of radicand per cycle
  assign trial   = res_r + sqbit_r;
  assign sq_ge   = (n_r >= trial);
  assign res_nxt = sq_ge ? ((res_r >> 1) + sqbit_r) : (res_r >> 1);

  // Restoring divide step, one quotient bit per cycle
  assign num   = (64'(a_r[idx_r]) << 30) + 64'(s_r >> 1);
  assign rem2  = {rem_r, q_r[31]};
  assign dv_ge = (rem2 >= 34'(s_r));
  assign q_nxt = {q_r[30:0], dv_ge};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_abs[i] = d_i[i][CW-1] ? (-d_i[i]) : d_i[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r[0]  <= '0;
      k_r[1]  <= '0;
      k_r[2]  <= KW'(1) << 30;
    end else if (start_i) begin
      state_r <= ST_LOAD;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
        end
        ST_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            a_r[i]   <= AW'(d_abs[i]);
            sgn_r[i] <= d_i[i][CW-1];
          end
          msq_r   <= '0;
          idx_r   <= '0;
          pass_r  <= 1'b0;
          state_r <= ST_SQ;
        end
        ST_SQ: begin
          msq_r <= msq_sum;
          idx_r <= idx_r + 2'd1;
          if (idx_r == 2'd2) begin
            if (pass_r) begin
              n_r     <= msq_sum;
              res_r   <= '0;
              sqbit_r <= 64'd1 << 62;
              cnt_r   <= '0;
              state_r <= ST_SQRT;
            end else begin
              state_r <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (msq_r <= SHORT_TH) begin
            // Direction too short to normalize: rescale to Q30 only
            for (int i = 0; i < 3; i++) begin
              k_r[i] <= KW'(d_i[i]) <<< (30 - FB);
            end
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (amax < (AW'(1) << 30)) begin
            for (int i = 0; i < 3; i++) begin
              a_r[i] <= a_r[i] << 1;
            end
          end else begin
            msq_r   <= '0;
            idx_r   <= '0;
            pass_r  <= 1'b1;
            state_r <= ST_SQ;
          end
        end
        ST_SQRT: begin
          if (sq_ge) n_r <= n_r - trial;
          res_r   <= res_nxt;
          sqbit_r <= sqbit_r >> 2;
          cnt_r   <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            s_r     <= res_nxt[32:0];
            idx_r   <= '0;
            state_r <= ST_DIV_INIT;
          end
        end
        ST_DIV_INIT: begin
          rem_r   <= 33'(num[63:32]);
          q_r     <= num[31:0];
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          rem_r <= dv_ge ? 33'(rem2 - 34'(s_r)) : rem2[32:0];
          q_r   <= q_nxt;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            k_r[idx_r] <= sgn_r[idx_r] ? KW'(-$signed({1'b0, q_nxt}))
                                       : KW'($signed({1'b0, q_nxt}));
            if (idx_r == 2'd2) begin
              state_r <= ST_IDLE;
            end else begin
              idx_r   <= idx_r + 2'd1;
              state_r <= ST_DIV_INIT;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign k_o    = k_r;
  assign busy_o = (state_r != ST_IDLE);

endmodule

@@ rtl/rpa_post.sv @@
// Rodrigues product stages: cross and dot terms, blend with sin/cos, saturate.
module rpa_post #(
  parameter int CW = 32,
  parameter int TW = 33
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid_i,
  input  logic signed [rpa_pkg::XW-1:0] cos_i,
  input  logic signed [rpa_pkg::XW-1:0] sin_i,
  input  logic signed [TW-1:0]          t_i [3],
  input  logic signed [rpa_pkg::KW-1:0] k_i [3],
  input  logic signed [CW-1:0]          a_i [3],
  output logic                          valid_o,
  output logic signed [CW-1:0]          new_o [3],
  output logic                          clipped_o
);

  localparam int KW  = rpa_pkg::KW;
  localparam int XW  = rpa_pkg::XW;
  localparam int P1W = KW + TW;
  localparam int P1X = P1W + 1;
  localparam int R1W = TW + 1;
  localparam int CCW = TW + 2;
  localparam int DW  = TW + 3;
  localparam int P2W = KW + DW;
  localparam int P2X = P2W + 1;
  localparam int UW  = DW + 1;
  localparam int P3W = TW + XW;
  localparam int P3X = P3W + 1;
  localparam int R3W = TW + 1;
  localparam int P4W = CCW + XW;
  localparam int P4X = P4W + 1;
  localparam int R4W = CCW + 1;
  localparam int P5W = UW + XW;
  localparam int P5X = P5W + 1;
  localparam int R5W = UW + 1;
  localparam int RW  = UW + 4;

  logic [5:0] vld_r;

  logic signed [P1W-1:0] pa1_r [3], pb1_r [3], pd1_r [3];
  logic signed [TW-1:0]  t1_r [3], t2_r [3];
  logic signed [XW-1:0]  cos1_r, sin1_r, cos2_r, sin2_r, cos3_r, cos4_r;
  logic signed [CCW-1:0] c2_r [3];
  logic signed [DW-1:0]  dot2_r;
  logic signed [P2W-1:0] pu3_r [3];
  logic signed [P3W-1:0] ptc3_r [3];
  logic signed [P4W-1:0] pcs3_r [3];
  logic signed [UW-1:0]  u4_r [3], u5_r [3];
  logic signed [R3W-1:0] tc4_r [3], tc5_r [3];
  logic signed [R4W-1:0] cs4_r [3], cs5_r [3];
  logic signed [P5W-1:0] puc5_r [3];
  logic signed [CW-1:0]  new_r [3];
  logic                  clip_r;

  logic signed [R1W-1:0] ra [3], rb [3], rd [3];
  logic signed [CCW-1:0] c_nxt [3];
  logic signed [DW-1:0]  dot_nxt;
  logic signed [UW-1:0]  u_nxt [3];
  logic signed [R3W-1:0] tc_nxt [3];
  logic signed [R4W-1:0] cs_nxt [3];
  logic signed [R5W-1:0] ruc [3];
  logic signed [RW-1:0]  r [3];
  logic [2:0]            over;
  logic signed [CW-1:0]  sat [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], valid_i};
    end
  end

  // Rounding of the first products, cross and dot terms
  always_comb begin
    dot_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      ra[i] = R1W'((P1X'(pa1_r[i]) + rpa_pkg::RND_HALF) >>> rpa_pkg::RND_SH);
      rb[i] = R1W'((P1X'(pb1_r[i]) + rpa_pkg::RND_HALF) >>> rpa_pkg::RND_SH);
      rd[i] = R1W'((P1X'(pd1_r[i]) + rpa_pkg::RND_HALF) >>> rpa_pkg::RND_SH);
      c_nxt[i] = CCW'(ra[i]) - CCW'(rb[i]);
      dot_nxt  = dot_nxt + DW'(rd[i]);
    end
  end

  // Rounding of the second products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_nxt[i]  = UW'((P2X'(pu3_r[i]) + rpa_pkg::RND_HALF) >>> rpa_pkg::RND_SH);
      tc_nxt[i] = R3W'((P3X'(ptc3_r[i]) + rpa_pkg::RND_HALF) >>> rpa_pkg::RND_SH);
      cs_nxt[i] = R4W'((P4X'(pcs3_r[i]) + rpa_pkg::RND_HALF) >>> rpa_pkg::RND_SH);
    end
  end

  // Final sum, translate back and saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ruc[i]  = R5W'((P5X'(puc5_r[i]) + rpa_pkg::RND_HALF) >>> rpa_pkg::RND_SH);
      r[i]    = RW'(tc5_r[i]) + RW'(cs5_r[i]) + RW'(u5_r[i]) - RW'(ruc[i]) + RW'(a_i[i]);
      over[i] = !((&r[i][RW-1:CW-1]) || !(|r[i][RW-1:CW-1]));
      if (over[i]) begin
        sat[i] = r[i][RW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
        sat[i] = r[i][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    // Stage 1: k times t
    for (int i = 0; i < 3; i++) begin
      pa1_r[i] <= k_i[(i + 1) % 3] * t_i[(i + 2) % 3];
      pb1_r[i] <= k_i[(i + 2) % 3] * t_i[(i + 1) % 3];
      pd1_r[i] <= k_i[i] * t_i[i];
    end
    t1_r   <= t_i;
    cos1_r <= cos_i;
    sin1_r <= sin_i;
    // Stage 2: cross product and dot product
    c2_r   <= c_nxt;
    dot2_r <= dot_nxt;
    t2_r   <= t1_r;
    cos2_r <= cos1_r;
    sin2_r <= sin1_r;
    // Stage 3: k*dot, t*cos, c*sin
    for (int i = 0; i < 3; i++) begin
      pu3_r[i]  <= k_i[i] * dot2_r;
      ptc3_r[i] <= t2_r[i] * cos2_r;
      pcs3_r[i] <= c2_r[i] * sin2_r;
    end
    cos3_r <= cos2_r;
    // Stage 4: round
    u4_r   <= u_nxt;
    tc4_r  <= tc_nxt;
    cs4_r  <= cs_nxt;
    cos4_r <= cos3_r;
    // Stage 5: u*cos
    for (int i = 0; i < 3; i++) begin
      puc5_r[i] <= u4_r[i] * cos4_r;
    end
    u5_r   <= u4_r;
    tc5_r  <= tc4_r;
    cs5_r  <= cs4_r;
    // Stage 6: result
    new_r  <= sat;
    clip_r <= |over;
  end

  assign valid_o   = vld_r[5];
  assign new_o     = new_r;
  assign clipped_o = clip_r;

endmodule

@@ rtl/rotate_point_about_axis_unit.sv @@
// Top level: rotates a point about a configured axis by Rodrigues' formula.
//
//  channel  ports                                   transfer when
//  -------  --------------------------------------  ---------------------------
//  input    start, busy, in_pos_x/y/z, in_turn_angle  start high, busy low
//  result   out_valid, out_new_x/y/z, out_clipped     out_valid high (one cycle)
//  config   cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid and cfg_ready high
//
// One point per cycle while busy is low; a result appears after its transfer
// has passed 2 entry stages, 30 CORDIC cells and 6 product stages.
// A write to a direction register runs the normalizer (sum of squares, square
// root, three restoring divides); busy stays high while it runs.
// Reset is synchronous; it loads the unit axis for the reset direction directly,
// so no pass runs after reset. Results cannot be held off by the receiver.
module rotate_point_about_axis_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [COORD_WIDTH-1:0]        in_pos_x,
  input  logic signed [COORD_WIDTH-1:0]        in_pos_y,
  input  logic signed [COORD_WIDTH-1:0]        in_pos_z,
  input  logic signed [rpa_pkg::ANG_W-1:0]     in_turn_angle,
  output logic                                 out_valid,
  output logic signed [COORD_WIDTH-1:0]        out_new_x,
  output logic signed [COORD_WIDTH-1:0]        out_new_y,
  output logic signed [COORD_WIDTH-1:0]        out_new_z,
  output logic                                 out_clipped,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rpa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [COORD_WIDTH-1:0]               cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int TW = CW + 1;
  localparam int XW = rpa_pkg::XW;
  localparam int ZW = rpa_pkg::ZW;
  localparam int N  = rpa_pkg::CORDIC_STEPS;

  logic signed [CW-1:0] axis_pt_r [3];
  logic signed [CW-1:0] dir_r [3];
  logic                 norm_start;
  logic                 norm_busy;
  logic signed [rpa_pkg::KW-1:0] k [3];

  logic                 acc;
  logic                 va_r, vb_r;
  logic signed [TW-1:0] ta_r [3], tb_r [3];
  logic signed [ZW-1:0] za_r, zb_r;
  logic                 negb_r;
  logic signed [ZW-1:0] z4, zred;
  logic signed [CW-1:0] pos [3];

  rpa_pkg::cord_ctl_t   ch_ctl [N+1];
  logic signed [XW-1:0] ch_x [N+1];
  logic signed [XW-1:0] ch_y [N+1];
  logic signed [ZW-1:0] ch_z [N+1];
  logic signed [TW-1:0] ch_t [N+1][3];

  logic signed [XW-1:0] cos_v;
  logic signed [CW-1:0] new_v [3];

  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;
  assign busy      = norm_busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_pt_r[0] <= '0;
      axis_pt_r[1] <= '0;
      axis_pt_r[2] <= '0;
      dir_r[0]     <= '0;
      dir_r[1]     <= '0;
      dir_r[2]     <= CW'(1) << FRAC_BITS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rpa_pkg::REG_AXIS_PX: axis_pt_r[0] <= cfg_data;
        rpa_pkg::REG_AXIS_PY: axis_pt_r[1] <= cfg_data;
        rpa_pkg::REG_AXIS_PZ: axis_pt_r[2] <= cfg_data;
        rpa_pkg::REG_DIR_X:   dir_r[0]     <= cfg_data;
        rpa_pkg::REG_DIR_Y:   dir_r[1]     <= cfg_data;
        rpa_pkg::REG_DIR_Z:   dir_r[2]     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign norm_start = cfg_valid && cfg_ready &&
                      (cfg_index inside {rpa_pkg::REG_DIR_X, rpa_pkg::REG_DIR_Y,
                                         rpa_pkg::REG_DIR_Z});

  rpa_norm #(.CW(CW), .FB(FRAC_BITS)) u_norm (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (norm_start),
    .d_i     (dir_r),
    .k_o     (k),
    .busy_o  (norm_busy)
  );

  // Entry stage A: translate, angle to Q30 and reduce into [-pi, pi)
  assign pos[0] = in_pos_x;
  assign pos[1] = in_pos_y;
  assign pos[2] = in_pos_z;
  assign z4     = ZW'(in_turn_angle) <<< 2;

  always_comb begin
    if (z4 >= rpa_pkg::PI_Q30) begin
      zred = z4 - rpa_pkg::TWO_PI_Q30;
    end else if (z4 < -rpa_pkg::PI_Q30) begin
      zred = z4 + rpa_pkg::TWO_PI_Q30;
    end else begin
      zred = z4;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= acc;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ta_r[i] <= TW'(pos[i]) - TW'(axis_pt_r[i]);
    end
    za_r <= zred;
    // Entry stage B: fold into [-pi/2, pi/2], negate cos when folded
    tb_r <= ta_r;
    if (za_r > rpa_pkg::HALF_PI_Q30) begin
      zb_r   <= rpa_pkg::PI_Q30 - za_r;
      negb_r <= 1'b1;
    end else if (za_r < -rpa_pkg::HALF_PI_Q30) begin
      zb_r   <= -rpa_pkg::PI_Q30 - za_r;
      negb_r <= 1'b1;
    end else begin
      zb_r   <= za_r;
      negb_r <= 1'b0;
    end
  end

  // CORDIC chain
  assign ch_ctl[0] = '{valid: vb_r, neg: negb_r};
  assign ch_x[0]   = rpa_pkg::CORDIC_GAIN;
  assign ch_y[0]   = '0;
  assign ch_z[0]   = zb_r;
  assign ch_t[0]   = tb_r;

  for (genvar g = 0; g < N; g++) begin : g_cell
    rpa_cell #(.STEP(g), .TW(TW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ch_ctl[g]),
      .x_i   (ch_x[g]),
      .y_i   (ch_y[g]),
      .z_i   (ch_z[g]),
      .t_i   (ch_t[g]),
      .ctl_o (ch_ctl[g+1]),
      .x_o   (ch_x[g+1]),
      .y_o   (ch_y[g+1]),
      .z_o   (ch_z[g+1]),
      .t_o   (ch_t[g+1])
    );
  end

  assign cos_v = ch_ctl[N].neg ? -ch_x[N] : ch_x[N];

  rpa_post #(.CW(CW), .TW(TW)) u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (ch_ctl[N].valid),
    .cos_i     (cos_v),
    .sin_i     (ch_y[N]),
    .t_i       (ch_t[N]),
    .k_i       (k),
    .a_i       (axis_pt_r),
    .valid_o   (out_valid),
    .new_o     (new_v),
    .clipped_o (out_clipped)
  );

  assign out_new_x = new_v[0];
  assign out_new_y = new_v[1];
  assign out_new_z = new_v[2];

endmodule

@@ rtl/rpa_check.sv @@
// Port-level checks for the rotation unit, bound to the top level.
module rpa_check (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [rpa_pkg::CFG_IDX_W-1:0] cfg_index
);

  localparam int LAT = rpa_pkg::PIPE_LAT;

  // Every transfer in gives a result at the end of the pipeline
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted point produced no result");

  // No result without a matching transfer in
  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without an accepted point");

  // Direction writes start the normalizer
  a_dir_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready &&
     (cfg_index == rpa_pkg::REG_DIR_X || cfg_index == rpa_pkg::REG_DIR_Y ||
      cfg_index == rpa_pkg::REG_DIR_Z)) |=> busy)
    else $error("direction write did not raise busy");

  // Reset flushes the pipeline
  a_rst_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule

bind rotate_point_about_axis_unit rpa_check u_rpa_check (.*);
